// ===== design/gef_pkg.sv =====
// Package for the frame-level Gilbert-Elliott loss block.
// Holds default widths, register indexes, sequencer states and divider status.
// No dependencies.
package gef_pkg;

    localparam int PROB_FRAC_BITS_DEF = 16;
    localparam int FRAME_LEN_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF     = 32;

    localparam int DRAW_BITS  = 14;
    localparam int BURST_BITS = 16;

    // draw scale: thresholds are out of 10000
    localparam logic [DRAW_BITS-1:0] DRAW_SCALE = 14'd10000;

    // configuration register indexes
    localparam logic REG_BAD_PROB  = 1'b0;
    localparam logic REG_BURST_LEN = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEN_MUL,
        ST_GB_LOAD,
        ST_GB_DIV,
        ST_POW_INIT,
        ST_POW_SQ,
        ST_POW_MB,
        ST_PB_MUL,
        ST_PGB_MUL,
        ST_PGB_DONE,
        ST_NUM_MUL,
        ST_PBG_LOAD,
        ST_PBG_DIV,
        ST_THR_MUL,
        ST_DECIDE
    } gef_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gef_div_stat_t;

endpackage

// ===== design/gef_qmul.sv =====
// Shared registered multiplier for the loss block sequencer.
// Full-width product, loaded only when enabled. Depends on nothing.
module gef_qmul #(
    parameter int W = 17
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] prod
);

    logic [2*W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== design/gef_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on gef_pkg for the status struct.
module gef_div
    import gef_pkg::*;
#(
    parameter int NUM_W = 33,
    parameter int DEN_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output gef_div_stat_t    stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [NUM_W-1:0] work_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic             busy;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign busy    = (cnt_reg != '0);
    assign shifted = {rem_reg, work_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy && (cnt_reg == CNT_W'(1));
            if (start) begin
                cnt_reg <= CNT_W'(NUM_W);
            end else if (busy) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (busy) begin
            work_reg <= {work_reg[NUM_W-2:0], ge};
            rem_reg  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign quot      = work_reg;
    assign stat.busy = busy;
    assign stat.done = done_reg;

endmodule

// ===== design/gilbert_elliott_frame_loss.sv =====
// Top level of the frame-level Gilbert-Elliott loss block.
// Depends on gef_pkg, gef_qmul (shared multiplier) and gef_div (serial divider).
//
// Usage:
//   cfg_*  : plain write port. cfg_addr 0 = bad_prob (Q0.F packet bad-state
//            probability), 1 = burst_len (mean burst in packets, 0 acts as 1).
//            Write only while the block is idle.
//   s_*    : one request per frame: packets in the frame and a uniform draw 0..9999.
//   m_*    : one result per request: lost flag, new state, frame bad-state
//            probability and saturating lost-frame count.
// Sequence: one request at a time. After acceptance the block runs the gb
//   divide, then square-and-multiply over the frame length bits (one shared
//   multiply per cycle), then the PB, PGB, threshold and decide steps; in the
//   bad state, when PB is not zero, a second divide forms PBG.
//   s_ready is high only while the sequencer is idle.
// Reset: state good, lost count zero, bad_prob 590, burst_len 150, no result.
// Receiver stall: the result sits in an output register; the next request
//   is still taken and computed, and waits at its last step until the
//   previous result is taken.
module gilbert_elliott_frame_loss
    import gef_pkg::*;
#(
    parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF,
    parameter int FRAME_LEN_BITS = FRAME_LEN_BITS_DEF,
    parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_wr_en,
    input  logic                      cfg_addr,
    input  logic [((PROB_FRAC_BITS > BURST_BITS) ? PROB_FRAC_BITS : BURST_BITS)-1:0] cfg_wdata,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [FRAME_LEN_BITS-1:0] s_frame_pkts,
    input  logic [DRAW_BITS-1:0]      s_random_draw,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_lost,
    output logic                      m_next_state,
    output logic [PROB_FRAC_BITS-1:0] m_frame_bad_prob,
    output logic [COUNT_BITS-1:0]     m_lost_total
);

    localparam int F      = PROB_FRAC_BITS;
    localparam int MUL_W  = (F + 1 > BURST_BITS) ? F + 1 : BURST_BITS;
    localparam int PROD_W = 2 * MUL_W;
    localparam int NUM_W  = 2 * F + 1;
    localparam int DEN_W  = F + BURST_BITS;
    localparam int IDX_W  = $clog2(FRAME_LEN_BITS);

    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    // configuration
    logic [F-1:0]          bad_prob_reg;
    logic [BURST_BITS-1:0] burst_len_reg;

    // control
    gef_state_t            state_reg, state_next;
    logic [IDX_W-1:0]      bit_idx_reg;
    logic                  bad_state_reg;
    logic [COUNT_BITS-1:0] lost_count_reg;
    logic                  m_valid_reg;

    // payload
    logic [FRAME_LEN_BITS-1:0] flen_reg;
    logic [DRAW_BITS-1:0]      draw_reg;
    logic [F:0]                omg_reg;   // one minus gb
    logic [F:0]                s_reg;
    logic [F:0]                pb_reg;
    logic [F:0]                pgb_reg;
    logic [F:0]                pbg_reg;
    logic                      m_lost_reg;
    logic                      m_next_state_reg;
    logic [F-1:0]              m_frame_bad_prob_reg;
    logic [COUNT_BITS-1:0]     m_lost_total_reg;

    // shared units
    logic                  mul_en;
    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [PROD_W-1:0]     mul_prod;
    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    logic [DEN_W-1:0]      div_den;
    logic [NUM_W-1:0]      div_quot;
    gef_div_stat_t         div_stat;

    logic [F:0]            q;          // Q0.F product
    logic [F:0]            quot_sat;
    logic [F:0]            p_ext;
    logic [BURST_BITS-1:0] len_eff;
    logic [DRAW_BITS-1:0]  thr;
    logic                  lost;
    logic                  accept;
    logic                  out_free;
    logic                  fire;

    assign p_ext    = {1'b0, bad_prob_reg};
    assign len_eff  = (burst_len_reg == '0) ? BURST_BITS'(1) : burst_len_reg;
    assign q        = mul_prod[F +: F + 1];
    assign quot_sat = (div_quot > NUM_W'(ONE)) ? ONE : div_quot[F:0];
    assign thr      = mul_prod[F +: DRAW_BITS];

    // good state: hit loses; bad state: hit recovers
    assign lost     = bad_state_reg ? !(draw_reg <= thr) : (draw_reg <= thr);

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = (state_reg == ST_DECIDE) && out_free;

    gef_qmul #(
        .W(MUL_W)
    ) u_mul (
        .aclk(aclk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .prod(mul_prod)
    );

    gef_div #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .quot   (div_quot),
        .stat   (div_stat)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (accept) state_next = ST_DEN_MUL;
            ST_DEN_MUL:  state_next = ST_GB_LOAD;
            ST_GB_LOAD:  state_next = ST_GB_DIV;
            ST_GB_DIV:   if (div_stat.done) state_next = ST_POW_INIT;
            ST_POW_INIT: state_next = ST_POW_SQ;
            ST_POW_SQ: begin
                if (flen_reg[bit_idx_reg]) begin
                    state_next = ST_POW_MB;
                end else if (bit_idx_reg == '0) begin
                    state_next = ST_PB_MUL;
                end
            end
            ST_POW_MB:   state_next = (bit_idx_reg == '0) ? ST_PB_MUL : ST_POW_SQ;
            ST_PB_MUL:   state_next = ST_PGB_MUL;
            ST_PGB_MUL:  state_next = ST_PGB_DONE;
            ST_PGB_DONE: begin
                // PBG is only needed from the bad state; PB of zero pins it to one
                if (bad_state_reg && (pb_reg != '0)) begin
                    state_next = ST_NUM_MUL;
                end else begin
                    state_next = ST_THR_MUL;
                end
            end
            ST_NUM_MUL:  state_next = ST_PBG_LOAD;
            ST_PBG_LOAD: state_next = ST_PBG_DIV;
            ST_PBG_DIV:  if (div_stat.done) state_next = ST_THR_MUL;
            ST_THR_MUL:  state_next = ST_DECIDE;
            ST_DECIDE:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // shared unit requests
    always_comb begin
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            ST_DEN_MUL: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(len_eff);
                mul_b  = MUL_W'(ONE - p_ext);
            end
            ST_GB_LOAD: begin
                div_start = 1'b1;
                div_num   = NUM_W'(bad_prob_reg) << F;
                div_den   = mul_prod[DEN_W-1:0];
            end
            ST_POW_INIT: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(ONE);
                mul_b  = MUL_W'(ONE);
            end
            ST_POW_SQ: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(q);
                mul_b  = MUL_W'(q);
            end
            ST_POW_MB: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(q);
                mul_b  = MUL_W'(omg_reg);
            end
            ST_PB_MUL: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(ONE - p_ext);
                mul_b  = MUL_W'(q);
            end
            ST_PGB_MUL: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(omg_reg);
                mul_b  = MUL_W'(s_reg);
            end
            ST_NUM_MUL: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(pgb_reg);
                mul_b  = MUL_W'(ONE - pb_reg);
            end
            ST_PBG_LOAD: begin
                div_start = 1'b1;
                div_num   = mul_prod[NUM_W-1:0];
                div_den   = DEN_W'(pb_reg);
            end
            ST_THR_MUL: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(bad_state_reg ? pbg_reg : pgb_reg);
                mul_b  = MUL_W'(DRAW_SCALE);
            end
            ST_IDLE, ST_GB_DIV, ST_PGB_DONE, ST_PBG_DIV, ST_DECIDE: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            bit_idx_reg    <= '0;
            bad_state_reg  <= 1'b0;
            lost_count_reg <= '0;
            m_valid_reg    <= 1'b0;
            bad_prob_reg   <= F'(590);
            burst_len_reg  <= BURST_BITS'(150);
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_BAD_PROB:  bad_prob_reg  <= cfg_wdata[F-1:0];
                    REG_BURST_LEN: burst_len_reg <= cfg_wdata[BURST_BITS-1:0];
                    default:       ;
                endcase
            end

            // frame length bits walk from the top down
            if (state_reg == ST_POW_INIT) begin
                bit_idx_reg <= IDX_W'(FRAME_LEN_BITS - 1);
            end else if (((state_reg == ST_POW_SQ) && !flen_reg[bit_idx_reg]) ||
                         (state_reg == ST_POW_MB)) begin
                if (bit_idx_reg != '0) begin
                    bit_idx_reg <= bit_idx_reg - IDX_W'(1);
                end
            end

            if (fire) begin
                m_valid_reg   <= 1'b1;
                bad_state_reg <= lost;
                if (lost && (lost_count_reg != '1)) begin
                    lost_count_reg <= lost_count_reg + COUNT_BITS'(1);
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            flen_reg <= s_frame_pkts;
            draw_reg <= s_random_draw;
        end
        if ((state_reg == ST_GB_DIV) && div_stat.done) begin
            omg_reg <= ONE - quot_sat;
        end
        if (state_reg == ST_PB_MUL) begin
            s_reg <= q;
        end
        if (state_reg == ST_PGB_MUL) begin
            pb_reg <= ONE - q;
        end
        if (state_reg == ST_PGB_DONE) begin
            pgb_reg <= ONE - q;
            if (pb_reg == '0) begin
                pbg_reg <= ONE;
            end
        end
        if ((state_reg == ST_PBG_DIV) && div_stat.done) begin
            pbg_reg <= quot_sat;
        end
        if (fire) begin
            m_lost_reg           <= lost;
            m_next_state_reg     <= lost;
            // PB of exactly one is reported as the largest fraction
            m_frame_bad_prob_reg <= pb_reg[F] ? {F{1'b1}} : pb_reg[F-1:0];
            if (lost && (lost_count_reg != '1)) begin
                m_lost_total_reg <= lost_count_reg + COUNT_BITS'(1);
            end else begin
                m_lost_total_reg <= lost_count_reg;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_lost           = m_lost_reg;
    assign m_next_state     = m_next_state_reg;
    assign m_frame_bad_prob = m_frame_bad_prob_reg;
    assign m_lost_total     = m_lost_total_reg;

endmodule

// ===== design/gef_checker.sv =====
// Port-level checks for the frame-level Gilbert-Elliott loss block.
// Depends on gilbert_elliott_frame_loss; attached by the bind at the end.
module gef_checker #(
    parameter int PROB_FRAC_BITS = 16,
    parameter int COUNT_BITS     = 32
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_lost,
    input logic                      m_next_state,
    input logic [PROB_FRAC_BITS-1:0] m_frame_bad_prob,
    input logic [COUNT_BITS-1:0]     m_lost_total
);

    // one request in flight: busy right after a request is taken
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready
    ) else $error("request accepted while previous one in flight");

    // a lost frame always leaves the channel in the bad state and vice versa
    a_lost_matches_state: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lost == m_next_state)
    ) else $error("lost flag and next state disagree");

    // a lost frame is counted
    a_lost_counted: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_lost |-> (m_lost_total != '0)
    ) else $error("lost frame with zero lost total");

    // stalled result holds
    a_result_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lost_total) &&
                                $stable(m_frame_bad_prob)
    ) else $error("stalled result changed");

endmodule

bind gilbert_elliott_frame_loss gef_checker #(
    .PROB_FRAC_BITS(PROB_FRAC_BITS),
    .COUNT_BITS    (COUNT_BITS)
) u_gef_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_lost          (m_lost),
    .m_next_state    (m_next_state),
    .m_frame_bad_prob(m_frame_bad_prob),
    .m_lost_total    (m_lost_total)
);

// ===== dv/gilbert_elliott_frame_loss_test.sv =====
// Self-checking bench for gilbert_elliott_frame_loss: random frames under several loss settings,
// each result checked against an in-bench model of the frame-level Gilbert-Elliott channel.
// Depends on gef_pkg and the gilbert_elliott_frame_loss RTL.
module gilbert_elliott_frame_loss_test;
    import gef_pkg::*;

    localparam int FRAC    = PROB_FRAC_BITS_DEF;
    localparam int FLEN_W  = FRAME_LEN_BITS_DEF;
    localparam int COUNT_W = COUNT_BITS_DEF;

    localparam longint unsigned Q_ONE     = 64'd1 << FRAC;
    localparam longint unsigned Q_MASK    = Q_ONE - 64'd1;
    localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_W) - 64'd1;

    // bound on the time from request to result (bad state), with margin
    localparam int LATENCY_MAX = 110;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic [FLEN_W-1:0]    pkts;
        logic [DRAW_BITS-1:0] draw;
    } frame_req_t;

    typedef struct {
        logic               lost;
        logic               bad;
        logic [FRAC-1:0]    bad_prob;
        logic [COUNT_W-1:0] lost_total;
    } frame_fate_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;

    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_addr = REG_BAD_PROB;
    logic [BURST_BITS-1:0] cfg_wdata = '0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [FLEN_W-1:0]     s_frame_pkts = '0;
    logic [DRAW_BITS-1:0]  s_random_draw = '0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_lost;
    logic                  m_next_state;
    logic [FRAC-1:0]       m_frame_bad_prob;
    logic [COUNT_W-1:0]    m_lost_total;

    gilbert_elliott_frame_loss dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_frame_pkts     (s_frame_pkts),
        .s_random_draw    (s_random_draw),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_lost           (m_lost),
        .m_next_state     (m_next_state),
        .m_frame_bad_prob (m_frame_bad_prob),
        .m_lost_total     (m_lost_total)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Channel model: its own copy of the registers and of the state.
    // ------------------------------------------------------------------
    logic [FRAC-1:0]       cfg_bad_prob  = 16'd590;
    logic [BURST_BITS-1:0] cfg_burst_len = 16'd150;
    logic                  chan_bad      = 1'b0;
    longint unsigned       loss_tally    = 0;

    frame_req_t  pending_frames[$];
    frame_fate_t expected_fates[$];
    int          mismatches = 0;

    // Q0.F product, truncated; exact when either side is one
    function automatic longint unsigned q_product(input longint unsigned a,
                                                  input longint unsigned b);
        if (a == Q_ONE) return b;
        if (b == Q_ONE) return a;
        return (a * b) >> FRAC;
    endfunction

    // frame-level PB, PGB and PBG for one frame length
    function automatic void loss_rates(input logic [FRAC-1:0] p_reg,
                                       input logic [BURST_BITS-1:0] len_reg,
                                       input logic [FLEN_W-1:0] flen,
                                       output longint unsigned pb,
                                       output longint unsigned pgb,
                                       output longint unsigned pbg);
        longint unsigned p, len, gb, stay, acc;
        int i;
        p   = p_reg;
        len = (len_reg == 0) ? 1 : len_reg;     // zero burst acts as one
        gb  = (p << FRAC) / (len * (Q_ONE - p));
        if (gb > Q_ONE) gb = Q_ONE;
        stay = Q_ONE - gb;
        // square-and-multiply from the top bit of the frame length down
        acc = Q_ONE;
        for (i = FLEN_W - 1; i >= 0; i--) begin
            acc = q_product(acc, acc);
            if (flen[i]) acc = q_product(acc, stay);
        end
        pb  = Q_ONE - q_product(Q_ONE - p, acc);
        pgb = Q_ONE - q_product(Q_ONE - gb, acc);
        if (pb == 0) begin
            pbg = Q_ONE;
        end else begin
            pbg = (pgb * (Q_ONE - pb)) / pb;
            if (pbg > Q_ONE) pbg = Q_ONE;
        end
    endfunction

    function automatic longint unsigned draw_limit(input longint unsigned prob);
        return (prob * longint'(DRAW_SCALE)) >> FRAC;
    endfunction

    // fate of one accepted frame; advances the channel state and loss tally
    function automatic frame_fate_t predict_frame_fate(input frame_req_t f);
        frame_fate_t     r;
        longint unsigned pb, pgb, pbg;
        logic            lost;
        loss_rates(cfg_bad_prob, cfg_burst_len, f.pkts, pb, pgb, pbg);
        if (!chan_bad) lost = (f.draw <= draw_limit(pgb));
        else           lost = !(f.draw <= draw_limit(pbg));
        chan_bad = lost;
        if (lost && loss_tally < COUNT_TOP) loss_tally++;
        r.lost       = lost;
        r.bad        = chan_bad;
        r.bad_prob   = (pb > Q_MASK) ? Q_MASK[FRAC-1:0] : pb[FRAC-1:0];
        r.lost_total = loss_tally[COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_frame(input int flen, input int draw);
        frame_req_t f;
        f.pkts = FLEN_W'(flen);
        f.draw = DRAW_BITS'(draw);
        pending_frames.push_back(f);
    endfunction

    // Random frame. Most draws land right around one of the two thresholds
    // so both branches of the state machine get exercised; the rest are
    // uniform, with a few beyond the nominal 0..9999 range.
    function automatic frame_req_t make_frame();
        frame_req_t      f;
        longint unsigned pb, pgb, pbg, rim;
        int              pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)      f.pkts = FLEN_W'($urandom_range(0, (1 << FLEN_W) - 1));
        else if (pick == 1) f.pkts = $urandom_range(0, 1) ? '1 : FLEN_W'($urandom_range(0, 2));
        else if (pick < 5)  f.pkts = FLEN_W'($urandom_range(1, 16));
        else                f.pkts = FLEN_W'($urandom_range(17, 400));
        loss_rates(cfg_bad_prob, cfg_burst_len, f.pkts, pb, pgb, pbg);
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            rim    = draw_limit($urandom_range(0, 1) ? pgb : pbg) + $urandom_range(0, 4);
            f.draw = (rim < 2) ? '0 : DRAW_BITS'(rim - 2);
        end else if (pick < 9) begin
            f.draw = DRAW_BITS'($urandom_range(0, DRAW_SCALE - 1));
        end else begin
            f.draw = DRAW_BITS'($urandom_range(0, (1 << DRAW_BITS) - 1));
        end
        return f;
    endfunction

    task automatic queue_random_frames(input int n);
        repeat (n) pending_frames.push_back(make_frame());
    endtask

    // registers are only touched with nothing in flight
    task automatic set_reg(input logic idx, input logic [BURST_BITS-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_BAD_PROB) cfg_bad_prob = val[FRAC-1:0];
        else                     cfg_burst_len = val;
    endtask

    task automatic set_channel(input logic [FRAC-1:0] p, input logic [BURST_BITS-1:0] len);
        set_reg(REG_BAD_PROB, p);
        set_reg(REG_BURST_LEN, len);
    endtask

    // sampled on the falling edge, clear of the clocked processes
    task automatic await_idle();
        @(negedge aclk);
        while (pending_frames.size() != 0 || s_valid || expected_fates.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Request driver: holds a request until taken, then sometimes idles before
    // the next one, with stretches of back-to-back requests.
    // ------------------------------------------------------------------
    int         tx_gap = 0;
    bit         tx_steady = 1'b0;
    frame_req_t taken_frame;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                taken_frame.pkts = s_frame_pkts;
                taken_frame.draw = s_random_draw;
                expected_fates.push_back(predict_frame_fate(taken_frame));
                if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
                tx_gap = tx_steady ? 0 : $urandom_range(0, 4);
            end
            if (s_valid && !s_ready) begin
                // request still waiting: payload and valid stay put
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_frames.size() > 0) begin
                taken_frame = pending_frames.pop_front();
                s_frame_pkts  <= taken_frame.pkts;
                s_random_draw <= taken_frame.draw;
                s_valid       <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each result and may stall after it.
    // A hold request from the sequence drops ready for HOLD_CYCLES so the
    // output register fills and the block backs up its input.
    // ------------------------------------------------------------------
    int          rx_stall = 0;
    int          hold_left = 0;
    bit          rx_steady = 1'b0;
    bit          hold_request = 1'b0;
    frame_fate_t due;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_fates.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    due = expected_fates.pop_front();
                    if (m_lost !== due.lost) begin
                        $error("lost: expected %0d, actual %0d", due.lost, m_lost);
                        mismatches++;
                    end
                    if (m_next_state !== due.bad) begin
                        $error("next_state: expected %0d, actual %0d", due.bad, m_next_state);
                        mismatches++;
                    end
                    if (m_frame_bad_prob !== due.bad_prob) begin
                        $error("frame_bad_prob: expected %0d, actual %0d",
                               due.bad_prob, m_frame_bad_prob);
                        mismatches++;
                    end
                    if (m_lost_total !== due.lost_total) begin
                        $error("lost_total: expected %0d, actual %0d",
                               due.lost_total, m_lost_total);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
                rx_stall = rx_steady ? 0 : $urandom_range(0, 4);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    int run;

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: frame length extremes, draw extremes, out-of-range draws
        queue_frame(0, 0);
        queue_frame(1, DRAW_SCALE - 1);
        queue_frame((1 << FLEN_W) - 1, 0);
        queue_frame((1 << FLEN_W) - 1, (1 << DRAW_BITS) - 1);
        queue_frame(1 << (FLEN_W - 1), DRAW_SCALE);
        queue_frame(5, 0);
        queue_frame(0, (1 << DRAW_BITS) - 1);
        queue_random_frames(200);
        // long receiver stall while requests keep coming
        hold_request = 1'b1;
        await_idle();

        // zero probability and zero burst: PB is zero, PBG pinned at one
        set_channel('0, '0);
        queue_frame(0, 0);
        queue_frame(100, 0);
        queue_frame((1 << FLEN_W) - 1, DRAW_SCALE - 1);
        queue_random_frames(50);
        await_idle();

        // gb saturates, PB reaches one and reports as ONE-1
        set_channel('1, 16'd1);
        queue_frame(1, 0);
        queue_frame(3, DRAW_SCALE - 1);
        queue_frame((1 << FLEN_W) - 1, DRAW_SCALE);
        queue_random_frames(50);
        await_idle();

        // smallest probability, longest burst
        set_channel(16'd1, '1);
        queue_frame(1, 0);
        queue_frame((1 << FLEN_W) - 1, 0);
        queue_random_frames(60);
        await_idle();

        set_channel('1, '1);
        queue_random_frames(40);
        await_idle();

        // assorted settings; mostly short bursts so both states come up often
        for (run = 0; run < 8; run++) begin
            if (run % 3 == 0)
                set_channel(FRAC'($urandom_range(1, Q_MASK)), BURST_BITS'($urandom_range(1, 65535)));
            else
                set_channel(FRAC'($urandom_range(2000, 30000)), BURST_BITS'($urandom_range(1, 40)));
            queue_random_frames(100);
            await_idle();
        end

        repeat (LATENCY_MAX) @(posedge aclk);
        if (mismatches == 0 && expected_fates.size() == 0) begin
            $display("gilbert_elliott_frame_loss_test passed");
        end else begin
            if (expected_fates.size() != 0)
                $error("%0d results never arrived", expected_fates.size());
            $display("gilbert_elliott_frame_loss_test failed");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #10_000_000;
        $display("gilbert_elliott_frame_loss_test failed");
        $finish;
    end

endmodule

// ===== gilbert_elliott_frame_loss.f =====
design/gef_pkg.sv
design/gef_qmul.sv
design/gef_div.sv
design/gilbert_elliott_frame_loss.sv
design/gef_checker.sv
dv/gilbert_elliott_frame_loss_test.sv
